// ===== sv/bmd_pkg.sv =====
// Shared types, codes and helper functions for the Bayer demosaic block.
// Used by all other modules under sv/ but bmd_ram; depends on nothing else.
package bmd_pkg;

  localparam int PIX_W = 8;
  localparam int CFG_W = 12;
  localparam int SUM_W = 15;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [4:0][PIX_W-1:0] pix5_t;
  typedef logic [4:0][4:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic first;
    logic second;
    logic penult;
    logic last;
  } bnd_t;

  typedef struct packed {
    logic shift;
    logic emit;
    logic frame_end;
    logic row_odd;
    logic col_odd;
    bnd_t row_b;
    bnd_t col_b;
  } ctl_t;

  // Mirrors a five-tap line about its center without repeating the edge tap.
  function automatic pix5_t mirror5(pix5_t v, bnd_t b);
    pix5_t m;
    m[0] = b.first ? v[4] : (b.second ? v[2] : v[0]);
    m[1] = b.first ? v[3] : v[1];
    m[2] = v[2];
    m[3] = b.last ? v[1] : v[3];
    m[4] = b.last ? v[0] : (b.penult ? v[2] : v[4]);
    return m;
  endfunction

  // Rounds a sum in sixteenths half up and saturates it to a pixel.
  function automatic pix_t finish(logic signed [SUM_W-1:0] s);
    logic signed [SUM_W:0] t;
    pix_t r;
    t = {s[SUM_W-1], s} + (SUM_W+1)'(8);
    if (t[SUM_W]) begin
      r = '0;
    end else if (t > (SUM_W+1)'(4095)) begin
      r = '1;
    end else begin
      r = t[11:4];
    end
    return r;
  endfunction

endpackage

// ===== sv/bayer_mhc_demosaic.sv =====
// Streaming 5x5 Malvar-He-Cutler demosaic of an RGGB Bayer stream.
// Registered in stage 1, window and result; one item per cycle unless stalled.
// The first 2W+2 pixels of a frame give no result; flush items drain the rest.
// Synchronous reset clears counters and valids; frame min(640,MAX_WIDTH)x480.
// Depends on bmd_pkg, bmd_ram (four line memories), bmd_ctrl and bmd_kernel.
module bayer_mhc_demosaic #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [bmd_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      kind,
  input  logic [7:0]                raw_pixel,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                red,
  output logic [7:0]                green,
  output logic [7:0]                blue,
  output logic                      frame_end
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic                adv;
  logic                acc;
  bmd_pkg::ctl_t       ctl;
  logic                wr;
  logic [AW-1:0]       addr;
  logic [1:0]          vrow;
  bmd_pkg::pix_t       rd [4];
  bmd_pkg::ctl_t       s1_ctl;
  bmd_pkg::pix_t       s1_pix;
  logic [1:0]          s1_vrow;
  bmd_pkg::pix5_t      vec;
  bmd_pkg::win_t       win;
  bmd_pkg::ctl_t       s2_ctl;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign acc      = in_valid && !in_stall;

  bmd_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .kind      (kind),
    .ctl       (ctl),
    .wr        (wr),
    .addr      (addr),
    .vrow      (vrow)
  );

  for (genvar k = 0; k < 4; k++) begin : g_line
    bmd_ram #(.WIDTH(bmd_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
      .clk   (clk),
      .we    (wr && vrow == 2'(k)),
      .waddr (addr),
      .wdata (raw_pixel),
      .re    (adv),
      .raddr (addr),
      .rdata (rd[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      s2_ctl <= '0;
    end else if (adv) begin
      s1_ctl <= ctl;
      s2_ctl <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix  <= raw_pixel;
      s1_vrow <= vrow;
    end
  end

  // Line memory k holds the rows whose number is k modulo four.
  always_comb begin
    unique case (s1_vrow)
      2'd0: vec = {s1_pix, rd[3], rd[2], rd[1], rd[0]};
      2'd1: vec = {s1_pix, rd[0], rd[3], rd[2], rd[1]};
      2'd2: vec = {s1_pix, rd[1], rd[0], rd[3], rd[2]};
      default: vec = {s1_pix, rd[2], rd[1], rd[0], rd[3]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv && s1_ctl.shift) begin
      win[0] <= vec;
      for (int j = 1; j < 5; j++) begin
        win[j] <= win[j-1];
      end
    end
  end

  bmd_kernel u_kernel (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .win       (win),
    .ctl       (s2_ctl),
    .out_valid (out_valid),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .frame_end (frame_end)
  );

  a_emit_shift: assert property (@(posedge clk) disable iff (rst)
    s1_ctl.emit |-> s1_ctl.shift)
    else $error("item emits without entering the window");

  a_end_valid: assert property (@(posedge clk) disable iff (rst)
    adv && s2_ctl.frame_end && s2_ctl.emit |=> out_valid && frame_end)
    else $error("frame end lost on its way to the output");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({red, green, blue, frame_end}))
    else $error("stalled result item changed");

endmodule

// ===== sv/bmd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Read returns the old contents on a same-address write; no package needed.
module bmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/bmd_ctrl.sv =====
// Frame geometry registers and raster position counters of the demosaic.
// Depends on bmd_pkg for the control struct and the register codes.
module bmd_ctrl #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [bmd_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         acc,
  input  logic                         kind,
  output bmd_pkg::ctl_t                ctl,
  output logic                         wr,
  output logic [$clog2(MAX_WIDTH)-1:0] addr,
  output logic [1:0]                   vrow
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int EW = (CW > 11) ? CW : 11;
  localparam logic [CW-1:0] W_MAX = CW'(MAX_WIDTH);
  localparam logic [CW-1:0] W_MIN = CW'(4);
  localparam logic [CW-1:0] W_RST = CW'((MAX_WIDTH < 640) ? MAX_WIDTH : 640);

  logic [CW-1:0] eff_w;
  logic [11:0]   eff_h;
  logic [CW-1:0] in_col;
  logic [11:0]   in_row;
  logic [CW-1:0] out_col;
  logic [11:0]   out_row;
  logic [CW-1:0] vcol;
  logic          all_in;
  logic          is_flush;
  logic          shift;
  logic          emit;
  logic          last_out;

  function automatic logic [CW-1:0] clamp_w(logic [10:0] v);
    logic [CW-1:0] r;
    if (EW'(v) < EW'(4)) begin
      r = W_MIN;
    end else if (EW'(v) > EW'(MAX_WIDTH)) begin
      r = W_MAX;
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  function automatic logic [11:0] clamp_h(logic [11:0] v);
    return (v < 12'd4) ? 12'd4 : v;
  endfunction

  assign all_in   = in_row >= eff_h;
  assign is_flush = kind == bmd_pkg::KIND_FLUSH;
  assign shift    = acc && (is_flush ? all_in : !all_in);
  assign emit     = shift && (is_flush ||
                    !(in_row < 12'd2 || (in_row == 12'd2 && in_col < CW'(2))));
  assign wr       = acc && !is_flush && !all_in;
  assign last_out = out_row == eff_h - 12'd1 && out_col == eff_w - CW'(1);
  assign addr     = vcol[AW-1:0];

  always_comb begin
    ctl.shift         = shift;
    ctl.emit          = emit;
    ctl.frame_end     = last_out;
    ctl.row_odd       = out_row[0];
    ctl.col_odd       = out_col[0];
    ctl.row_b.first   = out_row == 12'd0;
    ctl.row_b.second  = out_row == 12'd1;
    ctl.row_b.penult  = out_row == eff_h - 12'd2;
    ctl.row_b.last    = out_row == eff_h - 12'd1;
    ctl.col_b.first   = out_col == CW'(0);
    ctl.col_b.second  = out_col == CW'(1);
    ctl.col_b.penult  = out_col == eff_w - CW'(2);
    ctl.col_b.last    = out_col == eff_w - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w   <= W_RST;
      eff_h   <= 12'd480;
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      vcol    <= '0;
      vrow    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bmd_pkg::REG_WIDTH:  eff_w <= clamp_w(cfg_data[10:0]);
        bmd_pkg::REG_HEIGHT: eff_h <= clamp_h(cfg_data);
      endcase
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      vcol    <= '0;
      vrow    <= '0;
    end else if (emit && last_out) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      vcol    <= '0;
      vrow    <= '0;
    end else begin
      if (wr) begin
        if (in_col == eff_w - CW'(1)) begin
          in_col <= '0;
          in_row <= in_row + 12'd1;
        end else begin
          in_col <= in_col + CW'(1);
        end
      end
      if (shift) begin
        if (vcol == eff_w - CW'(1)) begin
          vcol <= '0;
          vrow <= vrow + 2'd1;
        end else begin
          vcol <= vcol + CW'(1);
        end
      end
      if (emit) begin
        if (out_col == eff_w - CW'(1)) begin
          out_col <= '0;
          out_row <= out_row + 12'd1;
        end else begin
          out_col <= out_col + CW'(1);
        end
      end
    end
  end

  a_write_col: assert property (@(posedge clk) disable iff (rst)
    wr |-> vcol == in_col)
    else $error("raw pixel written away from the window column");

  a_end_flush: assert property (@(posedge clk) disable iff (rst)
    emit && last_out |-> kind == bmd_pkg::KIND_FLUSH)
    else $error("frame end produced by a raw pixel");

  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> in_row == 12'd0 && out_row == 12'd0 && vcol == '0)
    else $error("positions not cleared by a register write");

endmodule

// ===== sv/bmd_kernel.sv =====
// Edge mirroring, Malvar-He-Cutler kernels and the result register.
// Depends on bmd_pkg for the window type, mirror5 and finish.
module bmd_kernel (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  bmd_pkg::win_t win,
  input  bmd_pkg::ctl_t ctl,
  output logic          out_valid,
  output logic [7:0]    red,
  output logic [7:0]    green,
  output logic [7:0]    blue,
  output logic          frame_end
);

  typedef logic signed [bmd_pkg::SUM_W-1:0] sum_t;

  bmd_pkg::win_t rc;
  bmd_pkg::win_t m;
  bmd_pkg::pix5_t line;
  sum_t ctr, n1, e1, n2, e2, dg;
  sum_t cross_sum, diag, horiz, vert;
  bmd_pkg::pix_t r_n, g_n, b_n;

  // The window holds the newest column at index 0 (column c + 2).
  always_comb begin
    line = '0;
    for (int j = 0; j < 5; j++) begin
      rc[j] = bmd_pkg::mirror5(win[j], ctl.row_b);
    end
    for (int i = 0; i < 5; i++) begin
      for (int p = 0; p < 5; p++) begin
        line[p] = rc[4-p][i];
      end
      m[i] = bmd_pkg::mirror5(line, ctl.col_b);
    end
  end

  always_comb begin
    ctr = sum_t'(m[2][2]);
    n1  = sum_t'(m[1][2]) + sum_t'(m[3][2]);
    e1  = sum_t'(m[2][1]) + sum_t'(m[2][3]);
    n2  = sum_t'(m[0][2]) + sum_t'(m[4][2]);
    e2  = sum_t'(m[2][0]) + sum_t'(m[2][4]);
    dg  = sum_t'(m[1][1]) + sum_t'(m[1][3]) + sum_t'(m[3][1]) + sum_t'(m[3][3]);
    cross_sum = ((n1 + e1) <<< 2) + (ctr <<< 3) - ((n2 + e2) <<< 1);
    diag  = (dg <<< 2) + (ctr <<< 3) + (ctr <<< 2) - ((n2 + e2) <<< 1) - (n2 + e2);
    horiz = (e1 <<< 3) + (ctr <<< 3) + (ctr <<< 1) - (e2 <<< 1) + n2 - (dg <<< 1);
    vert  = (n1 <<< 3) + (ctr <<< 3) + (ctr <<< 1) - (n2 <<< 1) + e2 - (dg <<< 1);
  end

  always_comb begin
    case ({ctl.row_odd, ctl.col_odd})
      2'b00: begin
        r_n = m[2][2];
        g_n = bmd_pkg::finish(cross_sum);
        b_n = bmd_pkg::finish(diag);
      end
      2'b11: begin
        r_n = bmd_pkg::finish(diag);
        g_n = bmd_pkg::finish(cross_sum);
        b_n = m[2][2];
      end
      2'b01: begin
        r_n = bmd_pkg::finish(horiz);
        g_n = m[2][2];
        b_n = bmd_pkg::finish(vert);
      end
      default: begin
        r_n = bmd_pkg::finish(vert);
        g_n = m[2][2];
        b_n = bmd_pkg::finish(horiz);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red       <= r_n;
      green     <= g_n;
      blue      <= b_n;
      frame_end <= ctl.frame_end;
    end
  end

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the bayer_mhc_demosaic streaming demosaic block.
// It holds a scoreboard with its own model of the window and line store, and
// drives raw and flush items with bursts, stalls and register changes.
// Depends on bmd_pkg and the RTL under sv/.
module tb;

  localparam int LIMIT = 400000;
  localparam int STORE_COLS = 1024;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } rgb_t;

  class demosaic_scoreboard;
    logic [7:0] line_mem [8*STORE_COLS];
    int unsigned width_reg = 640;
    int unsigned height_reg = 480;
    int unsigned in_col, in_row, out_col, out_row;
    rgb_t pending_rgb[$];
    int errors = 0;
    int checked = 0;
    int frames = 0;

    function int unsigned eff_w();
      if (width_reg < 4) return 4;
      if (width_reg > STORE_COLS) return STORE_COLS;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      if (height_reg < 4) return 4;
      if (height_reg > 4095) return 4095;
      return height_reg;
    endfunction

    function void set_reg(logic idx, logic [bmd_pkg::CFG_W-1:0] val);
      if (idx == bmd_pkg::REG_WIDTH) width_reg = val & 12'h7FF;
      else height_reg = val;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    endfunction

    function int reflect(int x, int n);
      if (x < 0) return -x;
      if (x >= n) return 2 * n - 2 - x;
      return x;
    endfunction

    function int tap(int dy, int dx, int h, int w);
      int rr, cc;
      rr = reflect(int'(out_row) + dy, h);
      cc = reflect(int'(out_col) + dx, w);
      return int'(line_mem[(rr % 8) * STORE_COLS + cc]);
    endfunction

    function logic [7:0] round_sat(int s);
      int t;
      t = s + 8;
      if (t < 0) return 8'd0;
      t = t / 16;
      if (t > 255) return 8'd255;
      return t[7:0];
    endfunction

    function void emit_pixel(int unsigned w, int unsigned h);
      int hh, ww, ctr, n1, e1, n2, e2, dg, cross_sum, diag, horiz, vert;
      rgb_t px;
      hh = h; ww = w;
      ctr = tap(0, 0, hh, ww);
      n1 = tap(-1, 0, hh, ww) + tap(1, 0, hh, ww);
      e1 = tap(0, -1, hh, ww) + tap(0, 1, hh, ww);
      n2 = tap(-2, 0, hh, ww) + tap(2, 0, hh, ww);
      e2 = tap(0, -2, hh, ww) + tap(0, 2, hh, ww);
      dg = tap(-1, -1, hh, ww) + tap(-1, 1, hh, ww) + tap(1, -1, hh, ww) + tap(1, 1, hh, ww);
      cross_sum = 4 * (n1 + e1) + 8 * ctr - 2 * (n2 + e2);
      diag = 4 * dg + 12 * ctr - 3 * (n2 + e2);
      horiz = 8 * e1 + 10 * ctr - 2 * e2 + n2 - 2 * dg;
      vert = 8 * n1 + 10 * ctr - 2 * n2 + e2 - 2 * dg;
      case ({out_row[0], out_col[0]})
        2'b00: begin
          px.red = ctr[7:0]; px.green = round_sat(cross_sum); px.blue = round_sat(diag);
        end
        2'b11: begin
          px.red = round_sat(diag); px.green = round_sat(cross_sum); px.blue = ctr[7:0];
        end
        2'b01: begin
          px.red = round_sat(horiz); px.green = ctr[7:0]; px.blue = round_sat(vert);
        end
        default: begin
          px.red = round_sat(vert); px.green = ctr[7:0]; px.blue = round_sat(horiz);
        end
      endcase
      px.frame_end = 1'b0;
      if (out_row == h - 1 && out_col == w - 1) begin
        px.frame_end = 1'b1;
        frames++;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
      pending_rgb.push_back(px);
    endfunction

    function void note_item(logic k, logic [7:0] p);
      int unsigned w, h, idx;
      bit all_in;
      w = eff_w();
      h = eff_h();
      all_in = in_row >= h;
      if (k == bmd_pkg::KIND_FLUSH) begin
        if (all_in) emit_pixel(w, h);
        return;
      end
      if (all_in) return;
      line_mem[(in_row % 8) * STORE_COLS + in_col] = p;
      idx = in_row * w + in_col;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (idx >= 2 * w + 2) emit_pixel(w, h);
    endfunction

    function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fe);
      rgb_t px;
      if (pending_rgb.size() == 0) begin
        $error("unexpected result item: red %0d green %0d blue %0d", r, g, b);
        errors++;
        return;
      end
      px = pending_rgb.pop_front();
      checked++;
      if (r !== px.red) begin
        $error("red: expected %0d, actual %0d", px.red, r);
        errors++;
      end
      if (g !== px.green) begin
        $error("green: expected %0d, actual %0d", px.green, g);
        errors++;
      end
      if (b !== px.blue) begin
        $error("blue: expected %0d, actual %0d", px.blue, b);
        errors++;
      end
      if (fe !== px.frame_end) begin
        $error("frame_end: expected %0d, actual %0d", px.frame_end, fe);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic cfg_index;
  logic [bmd_pkg::CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic kind;
  logic [7:0] raw_pixel;
  logic out_valid;
  logic out_stall;
  logic [7:0] red, green, blue;
  logic frame_end;

  demosaic_scoreboard sb = new();
  int cycles = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  bayer_mhc_demosaic u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .raw_pixel(raw_pixel),
    .out_valid(out_valid), .out_stall(out_stall),
    .red(red), .green(green), .blue(blue), .frame_end(frame_end)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin : receiver
    int mode, phase, hold_cnt;
    mode = 0; phase = 0; hold_cnt = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_pixel(red, green, blue, frame_end);
      if (hold_req && hold_cnt == 0) begin
        hold_cnt = 400;
        hold_req = 1'b0;
      end
      phase++;
      if (phase % 150 == 0) mode = $urandom_range(0, 3);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= (phase % 7 < 2);
          default: out_stall <= ($urandom_range(0, 99) < 70);
        endcase
      end
    end
  end

  task automatic send_item(logic k, logic [7:0] p);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    kind <= k;
    raw_pixel <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(k, p);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_rgb.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [bmd_pkg::CFG_W-1:0] val);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Sends npix raw pixels of the current frame with occasional stray items,
  // then the flush items that drain it when the frame is complete.
  task automatic run_frame(int npix, int noise_pct);
    int unsigned w, h;
    w = sb.eff_w();
    h = sb.eff_h();
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_item(bmd_pkg::KIND_FLUSH, 8'($urandom_range(0, 255)));
      send_item(bmd_pkg::KIND_PIXEL, 8'($urandom_range(0, 255)));
    end
    if (npix != w * h) return;
    if ($urandom_range(0, 99) < noise_pct * 4)
      send_item(bmd_pkg::KIND_PIXEL, 8'($urandom_range(0, 255)));
    for (int i = 0; i < 2 * w + 2; i++) begin
      send_item(bmd_pkg::KIND_FLUSH, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < noise_pct)
        send_item(bmd_pkg::KIND_PIXEL, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int unsigned w, h;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= bmd_pkg::REG_WIDTH;
    cfg_data <= '0;
    in_valid <= 1'b0;
    kind <= bmd_pkg::KIND_PIXEL;
    raw_pixel <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Smallest frame with a checkerboard of extremes, an early flush and a late pixel.
    write_reg(bmd_pkg::REG_WIDTH, 12'h804);
    write_reg(bmd_pkg::REG_HEIGHT, 12'd4);
    send_item(bmd_pkg::KIND_FLUSH, 8'hFF);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        send_item(bmd_pkg::KIND_PIXEL, ((r + c) % 2 != 0) ? 8'hFF : 8'h00);
    send_item(bmd_pkg::KIND_PIXEL, 8'h80);
    for (int i = 0; i < 10; i++) send_item(bmd_pkg::KIND_FLUSH, 8'h00);

    // Tallest height, abandoned part way by a register write.
    write_reg(bmd_pkg::REG_HEIGHT, 12'hFFF);
    run_frame(60, 5);
    // Widest setting, clamped from an oversized value, left before any result.
    write_reg(bmd_pkg::REG_WIDTH, 12'h7FF);
    write_reg(bmd_pkg::REG_HEIGHT, 12'd2);
    run_frame(300, 2);
    write_reg(bmd_pkg::REG_WIDTH, 12'd6);

    while (items_sent < 1850) begin
      if ($urandom_range(0, 9) < 7) begin
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 14);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 9);
        write_reg(bmd_pkg::REG_WIDTH, {$urandom_range(0, 1) == 1, 11'(w)});
        write_reg(bmd_pkg::REG_HEIGHT, 12'(h));
      end
      if (items_sent > 600 && !hold_done) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 19) == 0) begin
        run_frame($urandom_range(1, sb.eff_w() * sb.eff_h() - 1), 5);
        write_reg(bmd_pkg::REG_HEIGHT, 12'(sb.height_reg));
      end else begin
        run_frame(sb.eff_w() * sb.eff_h(), 5);
        if ($urandom_range(0, 4) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("tb: %0d items sent, %0d pixels checked over %0d completed frames,",
             items_sent, sb.checked, sb.frames);
    $display("tb: including extreme sizes, clamped registers and abandoned frames.");
    if (sb.errors == 0 && sb.pending_rgb.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/bmd_pkg.sv
sv/bmd_ram.sv
sv/bmd_ctrl.sv
sv/bmd_kernel.sv
sv/bayer_mhc_demosaic.sv
bench/tb.sv
